// ===== rtl/ip_range_asn_classifier_core_macros.svh =====
// assertion macros shared by the rtl
`ifndef IP_RANGE_ASN_CLASSIFIER_CORE_MACROS_SVH
`define IP_RANGE_ASN_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define IPAC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ipac assertion failed");
`define IPAC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ipac assertion failed");
`else
`define IPAC_ASSERT(lbl, clk, rstn, prop)
`define IPAC_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== rtl/ipac_pkg.sv =====
package ipac_pkg;

    localparam int RANGE_ENTRIES     = 64;
    localparam int BLOCK_ENTRIES     = 64;
    localparam int VPN_ENTRIES       = 64;
    localparam int DEFAULT_VPN_COUNT = 16;
    localparam int DEFAULT_VPN_AW    = 4;

    localparam int RANGE_AW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int BLOCK_AW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam int VPN_AW   = $clog2(VPN_ENTRIES);
    localparam int RANGE_CW = $clog2(RANGE_ENTRIES + 1);
    localparam int VPN_CW   = $clog2(VPN_ENTRIES + 1);

    localparam int SCAN_MAX_RB = (RANGE_ENTRIES > BLOCK_ENTRIES) ? RANGE_ENTRIES : BLOCK_ENTRIES;
    localparam int SCAN_MAX    = (SCAN_MAX_RB > VPN_ENTRIES) ? SCAN_MAX_RB : VPN_ENTRIES;
    localparam int SET_SCAN    = (BLOCK_ENTRIES > VPN_ENTRIES) ? BLOCK_ENTRIES : VPN_ENTRIES;
    localparam int SCAN_CW     = $clog2(SCAN_MAX + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] DEFAULT_VPN [DEFAULT_VPN_COUNT] = '{
        32'd57043,  32'd57652,  32'd212584, 32'd209921,
        32'd213234, 32'd35995,  32'd204118, 32'd44402,
        32'd49544,  32'd33303,  32'd57314,  32'd206843,
        32'd62092,  32'd57589,  32'd34549,  32'd36149
    };

    typedef enum logic [2:0] {
        OP_LOOKUP    = 3'd0,
        OP_ADD_RANGE = 3'd1,
        OP_BLOCK     = 3'd2,
        OP_UNBLOCK   = 3'd3,
        OP_ADD_VPN   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_LOOKUP,
        CMD_ADD_RANGE,
        CMD_BLOCK,
        CMD_UNBLOCK,
        CMD_ADD_VPN
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_RANGE_FULL = 2'd1,
        ST_SET_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_RANGE,
        ENG_SETS,
        ENG_FINISH
    } t_eng_state;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] ip;
        logic [31:0] first;
        logic [31:0] last;
        logic [31:0] asn;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

// ===== rtl/ipac_if.sv =====
interface ipac_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] ip_address;
    logic [31:0] range_first;
    logic [31:0] range_last;
    logic [31:0] asn_value;

    modport source (output valid, op, ip_address, range_first, range_last, asn_value,
                    input ready);
    modport sink (input valid, op, ip_address, range_first, range_last, asn_value,
                  output ready);
endinterface

interface ipac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] found_asn;
    logic        range_hit;
    logic        vpn_flag;
    logic        blocked_flag;
    logic [1:0]  status;

    modport source (output valid, found_asn, range_hit, vpn_flag, blocked_flag, status,
                    input ready);
    modport sink (input valid, found_asn, range_hit, vpn_flag, blocked_flag, status,
                  output ready);
endinterface

interface ipac_cfg_if;
    logic valid;
    logic ready;
    logic block_vpn_enable;

    modport source (output valid, block_vpn_enable, input ready);
    modport sink (input valid, block_vpn_enable, output ready);
endinterface

// ===== rtl/ip_range_asn_classifier_core.sv =====
// channel   dir  handshake        payload
// i_in      in   valid / ready    op, ip_address, range_first, range_last, asn_value
// o_out     out  valid / ready    found_asn, range_hit, vpn_flag, blocked_flag, status
// i_cfg     in   valid / ready    block_vpn_enable (always ready)
//
// add range and unused codes skip the scans and go straight to the finish state in the engine
// block, unblock and add vpn scan the set memories, S = 64 set entries scanned
// lookup scans up to R ranges, then the S set entries, R = ranges stored, one range memory read a cycle
// a two-entry command queue lets the input take items while the engine works
// reset is synchronous, active low; the result register holds until taken
module ip_range_asn_classifier_core
    import ipac_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ipac_in_if.sink    i_in,
    ipac_cfg_if.sink   i_cfg,
    ipac_out_if.source o_out
);

    logic    push;
    logic    pop;
    logic    q_full;
    t_cmd    cmd;
    t_q_head head;

    ipac_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    ipac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    ipac_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/ipac_front.sv =====
module ipac_front
    import ipac_pkg::*;
(
    ipac_in_if.sink i_in,
    input  logic    i_q_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_cmd.ip    = i_in.ip_address;
        o_cmd.first = i_in.range_first;
        o_cmd.last  = i_in.range_last;
        o_cmd.asn   = i_in.asn_value;
        unique case (i_in.op)
            OP_LOOKUP:    o_cmd.kind = CMD_LOOKUP;
            OP_ADD_RANGE: o_cmd.kind = CMD_ADD_RANGE;
            OP_BLOCK:     o_cmd.kind = CMD_BLOCK;
            OP_UNBLOCK:   o_cmd.kind = CMD_UNBLOCK;
            OP_ADD_VPN:   o_cmd.kind = CMD_ADD_VPN;
            default:      o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// ===== rtl/ipac_queue.sv =====
`include "ip_range_asn_classifier_core_macros.svh"

module ipac_queue
    import ipac_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic [QUEUE_AW-1:0] n_wr_ptr;
    logic [QUEUE_AW-1:0] n_rd_ptr;
    logic [QUEUE_CW-1:0] n_count;

    assign o_full       = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `IPAC_ASSERT(a_no_push_when_full, i_clk, i_rst_n, o_full |-> !i_push)
    `IPAC_ASSERT(a_no_pop_when_empty, i_clk, i_rst_n, i_pop |-> (r_count != '0))

endmodule

// ===== rtl/ipac_engine.sv =====
`include "ip_range_asn_classifier_core_macros.svh"

module ipac_engine
    import ipac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_head     i_head,
    output logic        o_pop,
    ipac_cfg_if.sink    i_cfg,
    ipac_out_if.source  o_out
);

    // range table and asn set memories
    logic [31:0] r_rng_start_mem [RANGE_ENTRIES];
    logic [31:0] r_rng_end_mem   [RANGE_ENTRIES];
    logic [31:0] r_rng_asn_mem   [RANGE_ENTRIES];
    logic [31:0] r_blk_mem       [BLOCK_ENTRIES];
    logic [31:0] r_vpn_mem       [VPN_ENTRIES];
    logic        r_blk_valid     [BLOCK_ENTRIES];

    logic [31:0] r_rd_start;
    logic [31:0] r_rd_end;
    logic [31:0] r_rd_asn;
    logic [31:0] r_rd_blk;
    logic [31:0] r_rd_vpn;

    t_eng_state          r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [31:0]         r_key, n_key;
    logic                r_hit, n_hit;
    logic                r_blk_hit, n_blk_hit;
    logic [BLOCK_AW-1:0] r_blk_idx, n_blk_idx;
    logic                r_free_found, n_free_found;
    logic [BLOCK_AW-1:0] r_free_idx, n_free_idx;
    logic                r_vpn_hit, n_vpn_hit;
    logic [SCAN_CW-1:0]  r_idx, n_idx;
    logic [SCAN_CW-1:0]  r_pidx;
    logic                r_pvalid, n_pvalid;
    logic [RANGE_CW-1:0] r_range_cnt;
    logic [VPN_CW-1:0]   r_vpn_cnt;
    logic                r_block_vpn;

    logic        r_out_valid;
    logic [31:0] r_out_found;
    logic        r_out_hit;
    logic        r_out_vpn;
    logic        r_out_blk;
    t_status     r_out_status;

    logic [31:0] n_out_found;
    logic        n_out_hit;
    logic        n_out_vpn;
    logic        n_out_blk;
    t_status     n_out_status;
    logic        out_ld;
    logic        out_free;
    logic        rng_we;
    logic        blk_we;
    logic        blk_clr;
    logic        vpn_we;
    logic        range_match;
    logic        blk_match;
    logic        blk_free;
    logic        vpn_match;
    logic [31:0] vpn_entry;

    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.found_asn    = r_out_found;
    assign o_out.range_hit    = r_out_hit;
    assign o_out.vpn_flag     = r_out_vpn;
    assign o_out.blocked_flag = r_out_blk;
    assign o_out.status       = r_out_status;

    assign out_free = !r_out_valid || o_out.ready;

    // compare side of the registered read pipeline
    assign range_match = r_pvalid && (r_cmd.ip >= r_rd_start) && (r_cmd.ip <= r_rd_end);
    assign vpn_entry   = (r_pidx < SCAN_CW'(DEFAULT_VPN_COUNT))
                         ? DEFAULT_VPN[r_pidx[DEFAULT_VPN_AW-1:0]] : r_rd_vpn;
    assign blk_match   = r_pvalid && (r_pidx < SCAN_CW'(BLOCK_ENTRIES))
                         && r_blk_valid[r_pidx[BLOCK_AW-1:0]] && (r_rd_blk == r_key);
    assign blk_free    = r_pvalid && (r_pidx < SCAN_CW'(BLOCK_ENTRIES))
                         && !r_blk_valid[r_pidx[BLOCK_AW-1:0]];
    assign vpn_match   = r_pvalid && (r_pidx < SCAN_CW'(r_vpn_cnt)) && (vpn_entry == r_key);

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_key          = r_key;
        n_hit          = r_hit;
        n_blk_hit      = r_blk_hit;
        n_blk_idx      = r_blk_idx;
        n_free_found   = r_free_found;
        n_free_idx     = r_free_idx;
        n_vpn_hit      = r_vpn_hit;
        n_idx          = r_idx;
        n_pvalid       = 1'b0;
        o_pop          = 1'b0;
        out_ld         = 1'b0;
        rng_we         = 1'b0;
        blk_we         = 1'b0;
        blk_clr        = 1'b0;
        vpn_we         = 1'b0;
        n_out_found    = '0;
        n_out_hit      = 1'b0;
        n_out_vpn      = 1'b0;
        n_out_blk      = 1'b0;
        n_out_status   = ST_OK;
        unique case (r_state)
            ENG_IDLE: begin
                if (i_head.valid) begin
                    o_pop        = 1'b1;
                    n_cmd        = i_head.cmd;
                    n_key        = i_head.cmd.asn;
                    n_hit        = 1'b0;
                    n_blk_hit    = 1'b0;
                    n_free_found = 1'b0;
                    n_vpn_hit    = 1'b0;
                    n_idx        = '0;
                    case (i_head.cmd.kind) inside
                        CMD_LOOKUP:             n_state = ENG_RANGE;
                        CMD_ADD_RANGE, CMD_NOP: n_state = ENG_FINISH;
                        default:                n_state = ENG_SETS;
                    endcase
                end
            end
            ENG_RANGE: begin
                if (range_match) begin
                    n_key   = r_rd_asn;
                    n_hit   = 1'b1;
                    n_idx   = '0;
                    n_state = ENG_SETS;
                end else if (r_idx < SCAN_CW'(r_range_cnt)) begin
                    n_pvalid = 1'b1;
                    n_idx    = r_idx + 1'b1;
                end else if (!r_pvalid) begin
                    n_key   = '0;
                    n_idx   = '0;
                    n_state = ENG_SETS;
                end
            end
            ENG_SETS: begin
                if (blk_match) begin
                    n_blk_hit = 1'b1;
                    n_blk_idx = r_pidx[BLOCK_AW-1:0];
                end
                if (blk_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_pidx[BLOCK_AW-1:0];
                end
                if (vpn_match) begin
                    n_vpn_hit = 1'b1;
                end
                if (r_idx < SCAN_CW'(SET_SCAN)) begin
                    n_pvalid = 1'b1;
                    n_idx    = r_idx + 1'b1;
                end else if (!r_pvalid) begin
                    n_state = ENG_FINISH;
                end
            end
            ENG_FINISH: begin
                if (out_free) begin
                    out_ld  = 1'b1;
                    n_state = ENG_IDLE;
                    unique case (r_cmd.kind)
                        CMD_LOOKUP: begin
                            n_out_found = r_key;
                            n_out_hit   = r_hit;
                            n_out_vpn   = (r_key != '0) && r_vpn_hit;
                            n_out_blk   = r_blk_hit || ((r_key != '0) && r_vpn_hit && r_block_vpn);
                        end
                        CMD_ADD_RANGE: begin
                            if (r_range_cnt < RANGE_CW'(RANGE_ENTRIES)) begin
                                rng_we = 1'b1;
                            end else begin
                                n_out_status = ST_RANGE_FULL;
                            end
                        end
                        CMD_BLOCK: begin
                            if (!r_blk_hit) begin
                                if (r_free_found) begin
                                    blk_we = 1'b1;
                                end else begin
                                    n_out_status = ST_SET_FULL;
                                end
                            end
                        end
                        CMD_UNBLOCK: begin
                            blk_clr = r_blk_hit;
                        end
                        CMD_ADD_VPN: begin
                            if (!r_vpn_hit) begin
                                if (r_vpn_cnt < VPN_CW'(VPN_ENTRIES)) begin
                                    vpn_we = 1'b1;
                                end else begin
                                    n_out_status = ST_SET_FULL;
                                end
                            end
                        end
                        default: begin
                            n_out_status = ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ENG_IDLE;
            r_pvalid    <= 1'b0;
            r_range_cnt <= '0;
            r_vpn_cnt   <= VPN_CW'(DEFAULT_VPN_COUNT);
            r_block_vpn <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BLOCK_ENTRIES; i++) begin
                r_blk_valid[i] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_pvalid <= n_pvalid;
            if (i_cfg.valid) begin
                r_block_vpn <= i_cfg.block_vpn_enable;
            end
            if (rng_we) begin
                r_range_cnt <= r_range_cnt + 1'b1;
            end
            if (vpn_we) begin
                r_vpn_cnt <= r_vpn_cnt + 1'b1;
            end
            if (blk_we) begin
                r_blk_valid[r_free_idx] <= 1'b1;
            end
            if (blk_clr) begin
                r_blk_valid[r_blk_idx] <= 1'b0;
            end
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_hit        <= n_hit;
        r_blk_hit    <= n_blk_hit;
        r_blk_idx    <= n_blk_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_vpn_hit    <= n_vpn_hit;
        r_idx        <= n_idx;
        r_pidx       <= r_idx;
        if (out_ld) begin
            r_out_found  <= n_out_found;
            r_out_hit    <= n_out_hit;
            r_out_vpn    <= n_out_vpn;
            r_out_blk    <= n_out_blk;
            r_out_status <= n_out_status;
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (rng_we) begin
            r_rng_start_mem[r_range_cnt[RANGE_AW-1:0]] <= r_cmd.first;
            r_rng_end_mem[r_range_cnt[RANGE_AW-1:0]]   <= r_cmd.last;
            r_rng_asn_mem[r_range_cnt[RANGE_AW-1:0]]   <= r_cmd.asn;
        end
        r_rd_start <= r_rng_start_mem[r_idx[RANGE_AW-1:0]];
        r_rd_end   <= r_rng_end_mem[r_idx[RANGE_AW-1:0]];
        r_rd_asn   <= r_rng_asn_mem[r_idx[RANGE_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_blk_mem[r_free_idx] <= r_key;
        end
        r_rd_blk <= r_blk_mem[r_idx[BLOCK_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (vpn_we) begin
            r_vpn_mem[r_vpn_cnt[VPN_AW-1:0]] <= r_key;
        end
        r_rd_vpn <= r_vpn_mem[r_idx[VPN_AW-1:0]];
    end

    `IPAC_ASSERT(a_range_scan_lookup_only, i_clk, i_rst_n, (r_state == ENG_RANGE) |-> (r_cmd.kind == CMD_LOOKUP))
    `IPAC_ASSERT(a_range_cnt_bound, i_clk, i_rst_n, r_range_cnt <= RANGE_CW'(RANGE_ENTRIES))
    `IPAC_ASSERT(a_unblock_clears, i_clk, i_rst_n, blk_clr |=> !r_blk_valid[$past(r_blk_idx)])

endmodule

// ===== tb/ip_range_asn_classifier_core_test.sv =====
module ip_range_asn_classifier_core_test;
    import ipac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = RANGE_ENTRIES + SET_SCAN + 16;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] ip;
        logic [31:0] first;
        logic [31:0] last;
        logic [31:0] asn;
    } t_probe;

    typedef struct packed {
        logic [31:0] found_asn;
        logic        range_hit;
        logic        vpn_flag;
        logic        blocked_flag;
        t_status     status;
    } t_verdict;

    typedef struct packed {
        t_probe   item;
        logic     typed;
        t_verdict want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ipac_in_if  in_ch();
    ipac_cfg_if cfg_ch();
    ipac_out_if out_ch();

    ip_range_asn_classifier_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the lookup tables
    logic [31:0] rng_lo [RANGE_ENTRIES];
    logic [31:0] rng_hi [RANGE_ENTRIES];
    logic [31:0] rng_asn [RANGE_ENTRIES];
    int          rng_used = 0;
    logic [31:0] blk_asn [BLOCK_ENTRIES];
    bit          blk_live [BLOCK_ENTRIES];
    logic [31:0] vpn_asn [VPN_ENTRIES];
    int          vpn_used = 0;
    bit          block_vpn_on = 1'b0;

    t_verdict    verdicts_due [$];
    t_row        table_rows [$];
    logic [31:0] asn_pool [$];
    int          errors = 0;
    int          cycles = 0;
    int          send_pct = 0;
    int          recv_pct = 0;

    function automatic bit is_vpn(logic [31:0] asn);
        for (int i = 0; i < vpn_used; i++)
            if (vpn_asn[i] == asn)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic int block_slot(logic [31:0] asn);
        for (int i = 0; i < BLOCK_ENTRIES; i++)
            if (blk_live[i] && blk_asn[i] == asn)
                return i;
        return -1;
    endfunction

    function automatic t_verdict classify_item(t_probe p);
        t_verdict v;
        int       slot;
        v = '0;
        v.status = ST_OK;
        case (p.op)
            OP_LOOKUP: begin
                for (int i = 0; i < rng_used; i++) begin
                    if (p.ip >= rng_lo[i] && p.ip <= rng_hi[i]) begin
                        v.found_asn = rng_asn[i];
                        v.range_hit = 1'b1;
                        break;
                    end
                end
                v.vpn_flag = (v.found_asn != 32'd0) && is_vpn(v.found_asn);
                v.blocked_flag = (block_slot(v.found_asn) >= 0) || (v.vpn_flag && block_vpn_on);
            end
            OP_ADD_RANGE: begin
                if (rng_used < RANGE_ENTRIES) begin
                    rng_lo[rng_used] = p.first;
                    rng_hi[rng_used] = p.last;
                    rng_asn[rng_used] = p.asn;
                    rng_used++;
                end else begin
                    v.status = ST_RANGE_FULL;
                end
            end
            OP_BLOCK: begin
                if (block_slot(p.asn) < 0) begin
                    slot = -1;
                    for (int i = 0; i < BLOCK_ENTRIES; i++) begin
                        if (!blk_live[i]) begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot >= 0) begin
                        blk_asn[slot] = p.asn;
                        blk_live[slot] = 1'b1;
                    end else begin
                        v.status = ST_SET_FULL;
                    end
                end
            end
            OP_UNBLOCK: begin
                slot = block_slot(p.asn);
                if (slot >= 0)
                    blk_live[slot] = 1'b0;
            end
            OP_ADD_VPN: begin
                if (!is_vpn(p.asn)) begin
                    if (vpn_used < VPN_ENTRIES) begin
                        vpn_asn[vpn_used] = p.asn;
                        vpn_used++;
                    end else begin
                        v.status = ST_SET_FULL;
                    end
                end
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic void put_row(logic [2:0] op, logic [31:0] ip, logic [31:0] first,
                                    logic [31:0] last, logic [31:0] asn, bit typed = 1'b0,
                                    logic [31:0] found = '0, bit hit = 1'b0, bit vpn = 1'b0,
                                    bit blk = 1'b0, t_status st = ST_OK);
        t_row r;
        r.item = '{op: op, ip: ip, first: first, last: last, asn: asn};
        r.typed = typed;
        r.want = '{found_asn: found, range_hit: hit, vpn_flag: vpn, blocked_flag: blk,
                   status: st};
        table_rows = {table_rows, r};
    endfunction

    function automatic logic [31:0] pick_asn();
        int          sel;
        logic [31:0] a;
        sel = $urandom_range(99, 0);
        if (sel < 30) begin
            a = vpn_asn[$urandom_range(vpn_used - 1, 0)];
        end else if (sel < 60 && asn_pool.size() > 0) begin
            a = asn_pool[$urandom_range(asn_pool.size() - 1, 0)];
        end else if (sel < 70) begin
            a = '0;
        end else begin
            a = $urandom;
            asn_pool = {asn_pool, a};
            if (asn_pool.size() > 24)
                void'(asn_pool.pop_front());
        end
        return a;
    endfunction

    // random addresses, and addresses inside, on and just outside the stored ranges
    function automatic logic [31:0] pick_addr();
        int              sel;
        int              r;
        longint unsigned span;
        longint unsigned offs;
        sel = $urandom_range(99, 0);
        if (rng_used == 0 || sel < 15)
            return $urandom;
        r = $urandom_range(rng_used - 1, 0);
        if (sel < 22)
            return rng_lo[r] - 32'd1;
        if (sel < 30)
            return rng_hi[r] + 32'd1;
        if (rng_lo[r] > rng_hi[r])
            return rng_lo[r];
        span = {32'd0, rng_hi[r]} - {32'd0, rng_lo[r]} + 64'd1;
        offs = {32'd0, $urandom} % span;
        return rng_lo[r] + offs[31:0];
    endfunction

    function automatic t_probe make_item();
        t_probe      p;
        int          sel;
        logic [31:0] base;
        int          live [$];
        p.op = OP_LOOKUP;
        p.ip = $urandom;
        p.first = $urandom;
        p.last = $urandom;
        p.asn = $urandom;
        sel = $urandom_range(99, 0);
        if (sel < 45) begin
            p.ip = pick_addr();
        end else if (sel < 65) begin
            p.op = OP_ADD_RANGE;
            base = $urandom_range(1, 0) ? $urandom : pick_addr();
            p.first = base;
            p.last = base + $urandom_range(4096, 0);
            if ($urandom_range(9, 0) == 0)
                p.last = base - $urandom_range(16, 1);
            p.asn = pick_asn();
        end else if (sel < 77) begin
            p.op = OP_BLOCK;
            p.asn = pick_asn();
        end else if (sel < 87) begin
            p.op = OP_UNBLOCK;
            foreach (blk_live[i])
                if (blk_live[i])
                    live = {live, i};
            if (live.size() > 0 && $urandom_range(9, 0) < 7)
                p.asn = blk_asn[live[$urandom_range(live.size() - 1, 0)]];
            else
                p.asn = pick_asn();
        end else if (sel < 95) begin
            p.op = OP_ADD_VPN;
            p.asn = pick_asn();
        end else if (sel < 97) begin
            p.op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
        end else begin
            p.op = 3'($urandom_range(OP_UNUSED_LAST, 0));
        end
        return p;
    endfunction

    task automatic send_item(t_probe p, bit typed, t_verdict want);
        t_verdict v;
        while ($urandom_range(99, 0) < send_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= p.op;
        in_ch.ip_address <= p.ip;
        in_ch.range_first <= p.first;
        in_ch.range_last <= p.last;
        in_ch.asn_value <= p.asn;
        do @(posedge i_clk); while (!in_ch.ready);
        v = classify_item(p);
        verdicts_due = {verdicts_due, typed ? want : v};
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_cfg(bit val);
        cfg_ch.block_vpn_enable <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        block_vpn_on = val;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_run(int n);
        for (int k = 0; k < n; k++) begin
            send_item(make_item(), 1'b0, '0);
            if ($urandom_range(59, 0) == 0)
                drain();
        end
    endtask

    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99, 0) >= recv_pct);

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.found_asn = out_ch.found_asn;
            got.range_hit = out_ch.range_hit;
            got.vpn_flag = out_ch.vpn_flag;
            got.blocked_flag = out_ch.blocked_flag;
            got.status = t_status'(out_ch.status);
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result found=%h hit=%b vpn=%b blk=%b st=%0d",
                         $time, got.found_asn, got.range_hit, got.vpn_flag,
                         got.blocked_flag, got.status);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (got !== want) begin
                    $display("%0t: expected found=%h hit=%b vpn=%b blk=%b st=%0d", $time,
                             want.found_asn, want.range_hit, want.vpn_flag,
                             want.blocked_flag, want.status);
                    $display("%0t: actual   found=%h hit=%b vpn=%b blk=%b st=%0d", $time,
                             got.found_asn, got.range_hit, got.vpn_flag,
                             got.blocked_flag, got.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_probe p;
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.ip_address = '0;
        in_ch.range_first = '0;
        in_ch.range_last = '0;
        in_ch.asn_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.block_vpn_enable = 1'b0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < DEFAULT_VPN_COUNT; i++)
            vpn_asn[i] = DEFAULT_VPN[i];
        vpn_used = DEFAULT_VPN_COUNT;
        foreach (blk_live[i])
            blk_live[i] = 1'b0;

        // empty tables, then blocked asn 0 on a miss
        put_row(OP_LOOKUP, 32'h0, '0, '0, '0, 1'b1);
        put_row(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 1'b1);
        put_row(OP_BLOCK, '0, '0, '0, 32'd0, 1'b1);
        put_row(OP_LOOKUP, 32'h1234_5678, '0, '0, '0, 1'b1, 32'd0, 1'b0, 1'b0, 1'b1);
        put_row(OP_UNBLOCK, '0, '0, '0, 32'd0, 1'b1);
        put_row(OP_UNBLOCK, '0, '0, '0, 32'd0, 1'b1);
        put_row(OP_LOOKUP, 32'h0, '0, '0, '0, 1'b1);
        // range extremes, inverted range, asn 0 range
        put_row(OP_ADD_RANGE, 32'hFFFF_FFFF, 32'h0, 32'h0, DEFAULT_VPN[0], 1'b1);
        put_row(OP_ADD_RANGE, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        put_row(OP_ADD_RANGE, '0, 32'd10, 32'd5, 32'd7, 1'b1);
        put_row(OP_ADD_RANGE, '0, 32'h100, 32'h1FF, 32'd100, 1'b1);
        put_row(OP_ADD_RANGE, '0, 32'h200, 32'h200, 32'd0, 1'b1);
        put_row(OP_LOOKUP, 32'h0, '0, '0, '0);
        put_row(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
        put_row(OP_LOOKUP, 32'd7, '0, '0, '0);
        put_row(OP_LOOKUP, 32'h150, '0, '0, '0);
        // repeated block, repeated vpn add
        put_row(OP_BLOCK, '0, '0, '0, 32'd100, 1'b1);
        put_row(OP_BLOCK, '0, '0, '0, 32'd100, 1'b1);
        put_row(OP_ADD_VPN, '0, '0, '0, 32'd100, 1'b1);
        put_row(OP_ADD_VPN, '0, '0, '0, DEFAULT_VPN[0], 1'b1);
        put_row(OP_LOOKUP, 32'h1FF, '0, '0, '0);
        put_row(OP_ADD_VPN, '0, '0, '0, 32'd0, 1'b1);
        put_row(OP_LOOKUP, 32'h200, '0, '0, '0);
        // unused codes
        put_row(OP_UNUSED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1'b1);
        put_row(OP_UNUSED_LAST, '0, '0, '0, '0, 1'b1);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_pct = 8;
        recv_pct = 52;
        @(negedge i_clk);

        foreach (table_rows[k])
            send_item(table_rows[k].item, table_rows[k].typed, table_rows[k].want);

        drain();
        write_cfg(1'b1);
        random_run(150);

        drain();
        write_cfg(1'b0);
        send_pct = 52;
        recv_pct = 8;
        // fill both asn sets with fresh values
        for (int k = 0; k < 120; k++) begin
            p = make_item();
            p.op = ($urandom_range(11, 0) < 7) ? OP_BLOCK : OP_ADD_VPN;
            p.asn = $urandom;
            send_item(p, 1'b0, '0);
        end
        random_run(80);

        drain();
        write_cfg(1'b1);
        send_pct = 0;
        recv_pct = 0;
        random_run(150);

        drain();
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ipac_pkg.sv
rtl/ipac_if.sv
rtl/ipac_front.sv
rtl/ipac_queue.sv
rtl/ipac_engine.sv
rtl/ip_range_asn_classifier_core.sv
tb/ip_range_asn_classifier_core_test.sv
